FILE: rtl/sgbq_pkg.sv
// sgbq_pkg: shared codes and widths for the spatial grid bucket query block.
// No dependencies.
package sgbq_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    localparam logic [1:0] CFG_CELL_SIZE = 2'd0;
    localparam logic [1:0] CFG_GRID_COLS = 2'd1;
    localparam logic [1:0] CFG_GRID_ROWS = 2'd2;

    localparam int CS_W  = 15;
    localparam int GRD_W = 5;
    localparam int ID_W  = 8;
    localparam int POS_W = 16;
    localparam int DIV_W = 16;
    localparam int IDX_W = 7;

    typedef logic signed [7:0] t_cellq;

endpackage

FILE: rtl/spatial_grid_bucket_query.sv
// spatial_grid_bucket_query: uniform grid spatial hash, insert / query / clear.
// Depends on sgbq_pkg. Holds the bucket fill memory and the bucket slot memory.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one command per beat: clear,
//   insert or query. Output channel (o_valid / i_stall) carries result beats.
//   Config port (i_cfg_we / i_cfg_idx / i_cfg_data) writes cell size and grid
//   size; write only while the block is idle.
// Timing:
//   One command at a time. Cell indices come from a shared 1-bit-per-cycle
//   divider: 2 divisions for insert, 4 for query. Insert: divisions, then
//   a bucket fill memory read and its single result. Query: divisions and
//   a setup step, then a fill memory read per grid cell walked and a slot
//   memory read per id found, then the final beat. Clear: done on
//   acceptance, with no result beat.
// Reset: configuration goes to cell size 16, 16 x 16 grid; all buckets empty
//   (per-bucket valid flags clear, slot memory is not initialized).
// Stall: results sit in one output register; insert and query hold before
//   loading a result while one waits, no beat is lost.
module spatial_grid_bucket_query
    import sgbq_pkg::*;
#(
    parameter int MAX_COLS     = 16,
    parameter int MAX_ROWS     = 16,
    parameter int BUCKET_DEPTH = 4,
    parameter int MAX_RESULTS  = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_opcode,
    input  logic [ID_W-1:0]         i_object_id,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic [CS_W-1:0]         i_radius,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [ID_W-1:0]         o_found_id,
    output logic                    o_id_valid,
    output logic                    o_last,
    output logic [1:0]              o_status,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [CS_W-1:0]         i_cfg_data
);

    localparam int NB = MAX_COLS * MAX_ROWS;
    localparam int NS = NB * BUCKET_DEPTH;
    localparam int BW = (NB > 1) ? $clog2(NB) : 1;
    localparam int SW = (NS > 1) ? $clog2(NS) : 1;
    localparam int FW = $clog2(BUCKET_DEPTH + 1);
    localparam int NW = $clog2(MAX_RESULTS + 1);
    localparam logic [IDX_W-1:0] MC = IDX_W'(MAX_COLS);
    localparam logic [IDX_W-1:0] MR = IDX_W'(MAX_ROWS);
    localparam logic [FW-1:0] DEPTH_F = FW'(BUCKET_DEPTH);
    localparam logic [NW-1:0] MAXR_N = NW'(MAX_RESULTS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DLOAD = 4'd1;
    localparam logic [3:0] S_DRUN  = 4'd2;
    localparam logic [3:0] S_IPREP = 4'd3;
    localparam logic [3:0] S_IRD   = 4'd4;
    localparam logic [3:0] S_IWR   = 4'd5;
    localparam logic [3:0] S_QINIT = 4'd6;
    localparam logic [3:0] S_QCELL = 4'd7;
    localparam logic [3:0] S_QFILL = 4'd8;
    localparam logic [3:0] S_QSLOT = 4'd9;
    localparam logic [3:0] S_QDATA = 4'd10;
    localparam logic [3:0] S_QDONE = 4'd11;

    logic [3:0]              r_state;
    logic [CS_W-1:0]         r_cell_size;
    logic [GRD_W-1:0]        r_grid_cols, r_grid_rows;
    logic                    r_isq;
    logic [ID_W-1:0]         r_id;
    logic signed [POS_W-1:0] r_x, r_y;
    logic [CS_W-1:0]         r_r;
    logic [1:0]              r_dk;
    logic [DIV_W-1:0]        r_dd;
    logic [CS_W-1:0]         r_rem;
    logic [3:0]              r_cnt;
    logic                    r_neg;
    t_cellq                  r_v [4];
    logic [IDX_W-1:0]        r_col, r_row, r_c0, r_c1, r_r1;
    logic [BW-1:0]           r_b;
    logic [FW-1:0]           r_k;
    logic [NW-1:0]           r_n;
    logic                    r_phave;
    logic [ID_W-1:0]         r_pid;
    logic [NB-1:0]           r_fvalid;
    logic [FW-1:0]           r_fill_q;
    logic [ID_W-1:0]         r_slot_q;
    logic                    r_ov;
    logic [ID_W-1:0]         r_oid;
    logic                    r_oidv, r_olast;
    logic [1:0]              r_ostat;

    logic [FW-1:0]   fill_mem [NB];
    logic [ID_W-1:0] slot_mem [NS];

    logic [CS_W-1:0]  cs;
    logic [IDX_W-1:0] cols, rows, cm1, rm1;
    logic signed [17:0] num;
    logic [DIV_W-1:0] mag;
    logic [CS_W:0]    rs;
    logic             ge;
    logic [DIV_W-1:0] nd;
    t_cellq           vq;
    logic [BW-1:0]    b_comb;
    logic [FW-1:0]    fill_cur;
    logic             fill_we, slot_we;
    logic [SW-1:0]    slot_waddr, slot_raddr;
    logic             can_load;
    logic             out_load;
    logic             in_acc;
    logic signed [7:0] s_cm1, s_rm1, c0s, r0s, c1s, r1s;

    assign cs   = (r_cell_size == '0) ? CS_W'(1) : r_cell_size;
    assign cols = (r_grid_cols == '0) ? IDX_W'(1)
                : ((IDX_W'(r_grid_cols) > MC) ? MC : IDX_W'(r_grid_cols));
    assign rows = (r_grid_rows == '0) ? IDX_W'(1)
                : ((IDX_W'(r_grid_rows) > MR) ? MR : IDX_W'(r_grid_rows));
    assign cm1  = cols - IDX_W'(1);
    assign rm1  = rows - IDX_W'(1);
    assign s_cm1 = $signed({1'b0, cm1});
    assign s_rm1 = $signed({1'b0, rm1});

    always_comb begin
        case (r_dk)
            2'd0: num = r_isq ? (18'(r_x) - $signed({3'b0, r_r})) : 18'(r_x);
            2'd1: num = r_isq ? (18'(r_y) - $signed({3'b0, r_r})) : 18'(r_y);
            2'd2: num = 18'(r_x) + $signed({3'b0, r_r});
            default: num = 18'(r_y) + $signed({3'b0, r_r});
        endcase
    end
    assign mag = num[17] ? DIV_W'(-num) : DIV_W'(num);

    assign rs = {r_rem, r_dd[DIV_W-1]};
    assign ge = rs >= {1'b0, cs};
    assign nd = {r_dd[DIV_W-2:0], ge};
    assign vq = (r_neg && nd != '0) ? -8'sd1
              : ((nd > DIV_W'(127)) ? 8'sd127 : $signed({1'b0, nd[6:0]}));

    assign c0s = (r_v[0] < 0) ? 8'sd0 : r_v[0];
    assign r0s = (r_v[1] < 0) ? 8'sd0 : r_v[1];
    assign c1s = (r_v[2] > s_cm1) ? s_cm1 : r_v[2];
    assign r1s = (r_v[3] > s_rm1) ? s_rm1 : r_v[3];

    assign b_comb   = BW'(32'(r_row) * 32'(cols) + 32'(r_col));
    assign fill_cur = r_fvalid[r_b] ? r_fill_q : '0;
    assign fill_we  = (r_state == S_IWR) && (fill_cur < DEPTH_F) && can_load;
    assign slot_we  = fill_we;
    assign slot_waddr = SW'(32'(r_b) * BUCKET_DEPTH + 32'(fill_cur));
    assign slot_raddr = SW'(32'(r_b) * BUCKET_DEPTH + 32'(r_k));
    assign can_load = !r_ov || !i_stall;
    assign out_load = can_load && ((r_state == S_IWR) || (r_state == S_QDONE)
                    || ((r_state == S_QDATA) && (r_phave || r_n == MAXR_N)));
    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            fill_mem[r_b] <= fill_cur + FW'(1);
        end
        r_fill_q <= fill_mem[b_comb];
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= r_id;
        end
        r_slot_q <= slot_mem[slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= out_load || (r_ov && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cell_size <= CS_W'(16);
            r_grid_cols <= GRD_W'(16);
            r_grid_rows <= GRD_W'(16);
            r_fvalid    <= '0;
            r_phave     <= 1'b0;
            r_n         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CELL_SIZE: r_cell_size <= i_cfg_data;
                    CFG_GRID_COLS: r_grid_cols <= i_cfg_data[GRD_W-1:0];
                    CFG_GRID_ROWS: r_grid_rows <= i_cfg_data[GRD_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_id  <= i_object_id;
                        r_x   <= i_pos_x;
                        r_y   <= i_pos_y;
                        r_r   <= i_radius;
                        r_isq <= (i_opcode == OP_QUERY);
                        r_dk  <= 2'd0;
                        r_n   <= '0;
                        r_phave <= 1'b0;
                        if (i_opcode == OP_CLEAR) begin
                            r_fvalid <= '0;
                        end else if (i_opcode == OP_INSERT || i_opcode == OP_QUERY) begin
                            r_state <= S_DLOAD;
                        end
                    end
                end
                S_DLOAD: begin
                    r_neg   <= num[17];
                    r_dd    <= mag;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DRUN;
                end
                S_DRUN: begin
                    r_dd  <= nd;
                    r_rem <= ge ? CS_W'(rs - {1'b0, cs}) : rs[CS_W-1:0];
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_v[r_dk] <= vq;
                        if ((!r_isq && r_dk == 2'd1) || r_dk == 2'd3) begin
                            r_state <= r_isq ? S_QINIT : S_IPREP;
                        end else begin
                            r_dk    <= r_dk + 2'd1;
                            r_state <= S_DLOAD;
                        end
                    end
                end
                S_IPREP: begin
                    r_col   <= (c0s > s_cm1) ? cm1 : c0s[IDX_W-1:0];
                    r_row   <= (r0s > s_rm1) ? rm1 : r0s[IDX_W-1:0];
                    r_state <= S_IRD;
                end
                S_IRD: begin
                    r_b     <= b_comb;
                    r_state <= S_IWR;
                end
                S_IWR: begin
                    if (can_load) begin
                        r_oid   <= '0;
                        r_oidv  <= 1'b0;
                        r_olast <= 1'b1;
                        r_ostat <= (fill_cur < DEPTH_F) ? ST_OK : ST_FULL;
                        if (fill_cur < DEPTH_F) begin
                            r_fvalid[r_b] <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_QINIT: begin
                    r_c0  <= c0s[IDX_W-1:0];
                    r_c1  <= c1s[IDX_W-1:0];
                    r_r1  <= r1s[IDX_W-1:0];
                    r_col <= c0s[IDX_W-1:0];
                    r_row <= r0s[IDX_W-1:0];
                    if (c1s < 0 || r1s < 0 || c0s > c1s || r0s > r1s) begin
                        r_state <= S_QDONE;
                    end else begin
                        r_state <= S_QCELL;
                    end
                end
                S_QCELL: begin
                    r_b     <= b_comb;
                    r_state <= S_QFILL;
                end
                S_QFILL: begin
                    r_k <= '0;
                    if (fill_cur == '0) begin
                        if (r_col == r_c1) begin
                            r_col   <= r_c0;
                            r_row   <= r_row + IDX_W'(1);
                            r_state <= (r_row == r_r1) ? S_QDONE : S_QCELL;
                        end else begin
                            r_col   <= r_col + IDX_W'(1);
                            r_state <= S_QCELL;
                        end
                    end else begin
                        r_state <= S_QSLOT;
                    end
                end
                S_QSLOT: begin
                    r_state <= S_QDATA;
                end
                S_QDATA: begin
                    if (r_n == MAXR_N) begin
                        if (can_load) begin
                            r_oid   <= r_pid;
                            r_oidv  <= 1'b1;
                            r_olast <= 1'b1;
                            r_ostat <= ST_TRUNC;
                            r_phave <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end else if (!r_phave || can_load) begin
                        if (r_phave) begin
                            r_oid   <= r_pid;
                            r_oidv  <= 1'b1;
                            r_olast <= 1'b0;
                            r_ostat <= ST_OK;
                        end
                        r_pid   <= r_slot_q;
                        r_phave <= 1'b1;
                        r_n     <= r_n + NW'(1);
                        if (r_k + FW'(1) < fill_cur) begin
                            r_k     <= r_k + FW'(1);
                            r_state <= S_QSLOT;
                        end else if (r_col == r_c1) begin
                            r_col   <= r_c0;
                            r_row   <= r_row + IDX_W'(1);
                            r_state <= (r_row == r_r1) ? S_QDONE : S_QCELL;
                        end else begin
                            r_col   <= r_col + IDX_W'(1);
                            r_state <= S_QCELL;
                        end
                    end
                end
                S_QDONE: begin
                    if (can_load) begin
                        r_oid   <= r_phave ? r_pid : '0;
                        r_oidv  <= r_phave;
                        r_olast <= 1'b1;
                        r_ostat <= ST_OK;
                        r_phave <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid    = r_ov;
    assign o_found_id = r_oid;
    assign o_id_valid = r_oidv;
    assign o_last     = r_olast;
    assign o_status   = r_ostat;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_id_valid) |-> (o_last && o_found_id == '0))
        else $error("empty result not final");
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_last)
        else $error("nonzero status on non-final beat");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= MAXR_N)
        else $error("result count overflow");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_we |-> (fill_cur < DEPTH_F))
        else $error("bucket overfill");

endmodule

FILE: bench/spatial_grid_bucket_query_test.sv
// spatial_grid_bucket_query_test: self-checking bench for the grid bucket query block.
// Drives insert / query / clear beats with random gaps and stalls, predicts every
// result beat in-bench; depends on sgbq_pkg and spatial_grid_bucket_query.
`timescale 1ns / 100ps

module spatial_grid_bucket_query_test;
    import sgbq_pkg::*;

    localparam int          MAXC      = 16;
    localparam int          MAXR      = 16;
    localparam int          DEPTH     = 4;
    localparam int          MAXRES    = 64;
    localparam int          LIMIT     = 1000000;
    localparam int          IDLE_WAIT = 200;
    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam int          NPHASE    = 6;
    localparam int          NRAND     = 45;

    typedef struct packed {
        logic [7:0] id;
        logic       vld;
        logic       last;
        logic [1:0] st;
    } beat_t;

    typedef struct {
        logic [1:0]         op;
        logic [7:0]         id;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        r;
        bit                 typed;
        beat_t              want;
    } cmd_row_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [1:0]              i_opcode;
    logic [7:0]              i_object_id;
    logic signed [15:0]      i_pos_x;
    logic signed [15:0]      i_pos_y;
    logic [14:0]             i_radius;
    logic                    o_valid;
    logic                    i_stall;
    logic [7:0]              o_found_id;
    logic                    o_id_valid;
    logic                    o_last;
    logic [1:0]              o_status;
    logic                    i_cfg_we;
    logic [1:0]              i_cfg_idx;
    logic [14:0]             i_cfg_data;

    spatial_grid_bucket_query u_top (.*);

    always #5 i_clk = ~i_clk;

    // grid shadow state
    int unsigned cell_sz, n_cols, n_rows;
    int unsigned fill[MAXC*MAXR];
    logic [7:0]  slots[MAXC*MAXR*DEPTH];
    beat_t       step_beats[$];
    beat_t       pending_beats[$];
    int          errors = 0;
    int          cycles = 0;
    bit          hold_go = 0;

    cmd_row_t dir_tab[13] = '{
        '{OP_QUERY,  8'h00, 16'sh0000, 16'sh0000, 15'd0,     1, '{8'h00, 1'b0, 1'b1, ST_OK}},
        '{OP_INSERT, 8'hFF, 16'sh8000, 16'sh8000, 15'd0,     1, '{8'h00, 1'b0, 1'b1, ST_OK}},
        '{OP_INSERT, 8'h01, 16'sh0000, 16'sh0000, 15'd0,     1, '{8'h00, 1'b0, 1'b1, ST_OK}},
        '{OP_INSERT, 8'h02, 16'sh0003, 16'sh0000, 15'd0,     1, '{8'h00, 1'b0, 1'b1, ST_OK}},
        '{OP_INSERT, 8'h03, 16'sh0000, 16'sh000F, 15'd0,     1, '{8'h00, 1'b0, 1'b1, ST_OK}},
        '{OP_INSERT, 8'h04, 16'sh0001, 16'sh0001, 15'd0,     1, '{8'h00, 1'b0, 1'b1, ST_FULL}},
        '{OP_INSERT, 8'hAA, 16'sh7FFF, 16'sh7FFF, 15'd0,     1, '{8'h00, 1'b0, 1'b1, ST_OK}},
        '{OP_QUERY,  8'h00, 16'sh0000, 16'sh0000, 15'd0,     0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{OP_QUERY,  8'h00, 16'sh7FFF, 16'sh7FFF, 15'h7FFF,  0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{OP_QUERY,  8'h00, 16'sh8000, 16'sh8000, 15'd0,     1, '{8'h00, 1'b0, 1'b1, ST_OK}},
        '{OP_UNUSED, 8'h55, 16'sh1234, 16'sh4321, 15'h2AAA,  0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{OP_CLEAR,  8'h00, 16'sh0000, 16'sh0000, 15'd0,     0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{OP_QUERY,  8'h00, 16'sh0000, 16'sh0000, 15'h7FFF,  1, '{8'h00, 1'b0, 1'b1, ST_OK}}
    };

    function automatic int clampi(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // expected beats of one command into step_beats; updates the shadow grid
    function automatic void grid_step(logic [1:0] op, logic [7:0] id,
                                      logic signed [15:0] px, logic signed [15:0] py,
                                      logic [14:0] rad);
        int    cs, nc, nr, x, y, r, c0, c1, r0, r1, b, n;
        bit    trunc;
        beat_t e;
        step_beats.delete();
        cs = (cell_sz == 0) ? 1 : cell_sz;
        nc = (n_cols == 0) ? 1 : (n_cols > MAXC) ? MAXC : n_cols;
        nr = (n_rows == 0) ? 1 : (n_rows > MAXR) ? MAXR : n_rows;
        x = px;
        y = py;
        r = rad;
        case (op)
            OP_CLEAR: begin
                foreach (fill[i]) fill[i] = 0;
            end
            OP_INSERT: begin
                b = clampi(y / cs, 0, nr - 1) * nc + clampi(x / cs, 0, nc - 1);
                e = '{8'h00, 1'b0, 1'b1, ST_OK};
                if (fill[b] >= DEPTH) begin
                    e.st = ST_FULL;
                end else begin
                    slots[b*DEPTH + fill[b]] = id;
                    fill[b]++;
                end
                step_beats = {step_beats, e};
            end
            OP_QUERY: begin
                c0 = (x - r) / cs;
                r0 = (y - r) / cs;
                c1 = (x + r) / cs;
                r1 = (y + r) / cs;
                if (c0 < 0) c0 = 0;
                if (r0 < 0) r0 = 0;
                if (c1 > nc - 1) c1 = nc - 1;
                if (r1 > nr - 1) r1 = nr - 1;
                n = 0;
                trunc = 0;
                for (int row = r0; row <= r1 && !trunc; row++) begin
                    for (int col = c0; col <= c1 && !trunc; col++) begin
                        b = row * nc + col;
                        for (int k = 0; k < fill[b]; k++) begin
                            if (n >= MAXRES) begin
                                trunc = 1;
                                break;
                            end
                            e = '{slots[b*DEPTH + k], 1'b1, 1'b0, ST_OK};
                            step_beats = {step_beats, e};
                            n++;
                        end
                    end
                end
                if (n == 0) begin
                    e = '{8'h00, 1'b0, 1'b1, ST_OK};
                    step_beats = {step_beats, e};
                end else begin
                    step_beats[n-1].last = 1'b1;
                    if (trunc) step_beats[n-1].st = ST_TRUNC;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one command beat; returns once it is accepted
    task automatic send_cmd(cmd_row_t c);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= c.op;
        i_object_id <= c.id;
        i_pos_x     <= c.x;
        i_pos_y     <= c.y;
        i_radius    <= c.r;
        do @(posedge i_clk); while (o_stall);
        grid_step(c.op, c.id, c.x, c.y, c.r);
        if (c.typed) begin
            pending_beats = {pending_beats, c.want};
        end else begin
            pending_beats = {pending_beats, step_beats};
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[14:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_CELL_SIZE: cell_sz = val[14:0];
            CFG_GRID_COLS: n_cols  = val[4:0];
            default:       n_rows  = val[4:0];
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_pos(int cs, int n);
        int v;
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        v = $urandom_range(0, n - 1) * cs + $urandom_range(0, cs - 1);
        if (v > 32767) v = 32767;
        if ($urandom_range(0, 9) == 0) v = -v;
        return 16'(v);
    endfunction

    task automatic rand_cmd(output cmd_row_t c, input bit big_query);
        int p, cs, nc, nr, rr;
        cs = (cell_sz == 0) ? 1 : cell_sz;
        nc = (n_cols == 0) ? 1 : (n_cols > MAXC) ? MAXC : n_cols;
        nr = (n_rows == 0) ? 1 : (n_rows > MAXR) ? MAXR : n_rows;
        p = $urandom_range(0, 99);
        c.op    = (p < 62) ? OP_INSERT : (p < 95) ? OP_QUERY
                : (p < 97) ? OP_CLEAR : OP_UNUSED;
        if (big_query) c.op = OP_QUERY;
        c.id    = 8'($urandom);
        c.x     = rand_pos(cs, nc);
        c.y     = rand_pos(cs, nr);
        rr      = ($urandom_range(0, 7) == 0 || big_query) ? $urandom_range(0, 32767)
                                                           : $urandom_range(0, 2 * cs);
        if (rr > 32767) rr = 32767;
        c.r     = 15'(rr);
        c.typed = 0;
        c.want  = '0;
    endtask

    // result side: random stall, one long hold-off when asked
    initial begin
        int pct, hold_left;
        bit hold_taken;
        beat_t e;
        pct = 0;
        hold_left = 0;
        hold_taken = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                if (pending_beats.size() == 0) begin
                    $display("%0t unexpected beat: got id %h vld %b last %b st %0d", $time,
                             o_found_id, o_id_valid, o_last, o_status);
                    errors++;
                end else begin
                    e = pending_beats.pop_front();
                    if ({o_found_id, o_id_valid, o_last, o_status} !== e) begin
                        $display({"%0t mismatch: exp id %h vld %b last %b st %0d, ",
                                  "got id %h vld %b last %b st %0d"},
                                 $time, e.id, e.vld, e.last, e.st,
                                 o_found_id, o_id_valid, o_last, o_status);
                        errors++;
                    end
                end
            end
            if (hold_go && !hold_taken) begin
                hold_taken = 1;
                hold_left = 600;
            end
            if (cycles % 64 == 0) pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int unsigned cs_tab[NPHASE]   = '{16, 1, 32767, 5, 16, 3};
        int unsigned cols_tab[NPHASE] = '{16, 1, 16, 7, 3, 16};
        int unsigned rows_tab[NPHASE] = '{16, 1, 16, 3, 16, 1};
        cmd_row_t c;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_stall     <= 1'b0;
        i_opcode    <= OP_CLEAR;
        i_object_id <= '0;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_radius    <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_CELL_SIZE;
        i_cfg_data  <= '0;
        cell_sz = 16;
        n_cols  = 16;
        n_rows  = 16;
        foreach (fill[i]) fill[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (IDLE_WAIT) @(posedge i_clk);

        foreach (dir_tab[i]) send_cmd(dir_tab[i]);

        for (int ph = 0; ph < NPHASE; ph++) begin
            drain();
            cfg_write(CFG_CELL_SIZE, cs_tab[ph]);
            cfg_write(CFG_GRID_COLS, cols_tab[ph]);
            cfg_write(CFG_GRID_ROWS, rows_tab[ph]);
            if (ph == 0) hold_go = 1;
            for (int k = 0; k < NRAND; k++) begin
                rand_cmd(c, (k % 15) == 14);
                send_cmd(c);
            end
        end

        drain();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
